// ===== src/scp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, widths and register indexes for the sphere/cone test pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

    // pipeline depth, output register included
    localparam int NSTAGE = 12;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_RADIUS   = 2'd3;

    // stream payload widths
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 8;

    // field widths
    localparam int CW   = 32;   // coordinate, Q16.16
    localparam int DIRW = 16;   // axis component, Q1.15
    localparam int TRGW = 15;   // cos / sin, Q0.15
    localparam int RADW = 31;   // radius

    // datapath widths, sized from operand ranges so nothing wraps
    localparam int EW    = 33;  // C - V
    localparam int SNEW  = 48;  // sin * e
    localparam int RAW   = 47;  // r * axis
    localparam int AEW   = 48;  // axis * e
    localparam int DPW   = 49;  // D' component
    localparam int DPMW  = 48;  // |D'| component
    localparam int ADPW  = 64;  // axis * D'
    localparam int DOTW  = 66;  // A.D'
    localparam int NW    = 51;  // n = -A.E
    localparam int NMW   = 49;  // n when n >= 0
    localparam int ESQW  = 64;  // e^2
    localparam int ELW   = 66;  // |E|^2
    localparam int C2W   = 30;  // cos^2, sin^2
    localparam int DPSQW = 96;  // D'_i^2
    localparam int LENW  = 98;  // |D'|^2
    localparam int SQW   = 130; // (A.D')^2
    localparam int RHSW  = 128; // |D'|^2 * cos^2
    localparam int NSQW  = 98;  // n^2
    localparam int ESNW  = 96;  // |E|^2 * sin^2
    localparam int R2W   = 62;  // r^2

    typedef logic [NSTAGE:1] stage_en_t;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic [RADW-1:0]      radius;
    } sphere_t;

    typedef struct packed {
        logic signed [CW-1:0]   apex_x;
        logic signed [CW-1:0]   apex_y;
        logic signed [CW-1:0]   apex_z;
        logic signed [DIRW-1:0] dir_x;
        logic signed [DIRW-1:0] dir_y;
        logic signed [DIRW-1:0] dir_z;
        logic [TRGW-1:0]        half_cos;
        logic [TRGW-1:0]        half_sin;
    } cone_t;

    // vector terms handed from the front end to the quadratic back end
    typedef struct {
        logic signed [ADPW-1:0] adp [3];
        logic [DPMW-1:0]        dpabs [3];
        logic [ELW-1:0]         elen2;
        logic signed [NW-1:0]   n;
        logic [C2W-1:0]         cs2;
        logic [C2W-1:0]         sn2;
    } front_t;

endpackage

// ===== src/scp_wmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_wmul
// Pipelined wide unsigned multiplier: limb products, row sums, final sum.
// ----------------------------------------------------------------------------
module scp_wmul #(
    parameter int AW = 48,
    parameter int BW = 48,
    parameter int LW = 24
) (
    input  logic            clk,
    input  logic [2:0]      en,     // [0] limb products, [1] rows, [2] result
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    localparam int NA  = (AW + LW - 1) / LW;
    localparam int NB  = (BW + LW - 1) / LW;
    localparam int XA  = NA * LW;
    localparam int XB  = NB * LW;
    localparam int PPW = 2 * LW;
    localparam int RW  = LW + XB;
    localparam int SW  = XA + XB;
    localparam int PW  = AW + BW;

    logic [XA-1:0]  a_x;
    logic [XB-1:0]  b_x;
    logic [PPW-1:0] pp_reg [NA][NB];
    logic [RW-1:0]  row_next [NA];
    logic [RW-1:0]  row_reg [NA];
    logic [SW-1:0]  sum_next;
    logic [PW-1:0]  p_reg;

    assign a_x = XA'(a);
    assign b_x = XB'(b);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NA; i++)
                for (int j = 0; j < NB; j++)
                    pp_reg[i][j] <= PPW'(a_x[i*LW +: LW]) * PPW'(b_x[j*LW +: LW]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * LW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            row_reg <= row_next;
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
            sum_next = sum_next + (SW'(row_reg[i]) << (i * LW));
    end

    // true product always fits PW bits
    always_ff @(posedge clk)
    begin
        if (en[2])
            p_reg <= sum_next[PW-1:0];
    end

    assign p = p_reg;

endmodule

// ===== src/scp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_front
// Stages 1-4: E = C - V, scaled D' = sin*E + r*A, A.E, axis products.
// ----------------------------------------------------------------------------
module scp_front (
    input  logic               clk,
    input  scp_pkg::stage_en_t en,
    input  scp_pkg::sphere_t   sph,
    input  scp_pkg::cone_t     cone,
    output scp_pkg::front_t    f
);

    logic signed [scp_pkg::CW-1:0]   c [3];
    logic signed [scp_pkg::CW-1:0]   v [3];
    logic signed [scp_pkg::DIRW-1:0] a [3];
    logic signed [scp_pkg::TRGW:0]   sn_s;
    logic signed [scp_pkg::RADW:0]   rad_s;

    // stage 1
    logic signed [scp_pkg::EW-1:0]   e1_next [3];
    logic signed [scp_pkg::EW-1:0]   e1_reg [3];
    logic signed [scp_pkg::DIRW-1:0] a1_reg [3];
    logic [scp_pkg::TRGW-1:0]        sn1_reg;
    logic [scp_pkg::C2W-1:0]         cs2_1_next;
    logic [scp_pkg::C2W-1:0]         sn2_1_next;

    // stage 2
    logic signed [scp_pkg::SNEW-1:0] sne2_next [3];
    logic signed [scp_pkg::SNEW-1:0] sne2_reg [3];
    logic signed [scp_pkg::RAW-1:0]  rada2_next [3];
    logic signed [scp_pkg::RAW-1:0]  rada2_reg [3];
    logic signed [scp_pkg::AEW-1:0]  ae2_next [3];
    logic signed [scp_pkg::AEW-1:0]  ae2_reg [3];
    logic signed [scp_pkg::EW-1:0]   eneg [3];
    logic [scp_pkg::EW-2:0]          eabs2_next [3];
    logic [scp_pkg::EW-2:0]          eabs2_reg [3];
    logic signed [scp_pkg::DIRW-1:0] a2_reg [3];

    // stage 3
    logic signed [scp_pkg::DPW-1:0]  dp3_next [3];
    logic signed [scp_pkg::DPW-1:0]  dp3_reg [3];
    logic signed [scp_pkg::NW-1:0]   n3_next;
    logic signed [scp_pkg::NW-1:0]   n3_reg;
    logic [scp_pkg::ESQW-1:0]        esq3_next [3];
    logic [scp_pkg::ESQW-1:0]        esq3_reg [3];
    logic signed [scp_pkg::DIRW-1:0] a3_reg [3];

    // stage 4
    logic signed [scp_pkg::ADPW-1:0] adp4_next [3];
    logic signed [scp_pkg::ADPW-1:0] adp4_reg [3];
    logic signed [scp_pkg::DPW-1:0]  dpneg [3];
    logic [scp_pkg::DPMW-1:0]        dpabs4_next [3];
    logic [scp_pkg::DPMW-1:0]        dpabs4_reg [3];
    logic [scp_pkg::ELW-1:0]         elen2_4_next;
    logic [scp_pkg::ELW-1:0]         elen2_4_reg;
    logic signed [scp_pkg::NW-1:0]   n4_reg;

    // cos^2 and sin^2 ride along stages 1-4
    logic [scp_pkg::C2W-1:0] cs2_reg [1:4];
    logic [scp_pkg::C2W-1:0] sn2_reg [1:4];

    assign c[0] = sph.center_x;
    assign c[1] = sph.center_y;
    assign c[2] = sph.center_z;
    assign v[0] = cone.apex_x;
    assign v[1] = cone.apex_y;
    assign v[2] = cone.apex_z;
    assign a[0] = cone.dir_x;
    assign a[1] = cone.dir_y;
    assign a[2] = cone.dir_z;

    assign sn_s  = signed'({1'b0, sn1_reg});
    assign rad_s = signed'({1'b0, sph.radius});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            e1_next[i] = scp_pkg::EW'(c[i]) - scp_pkg::EW'(v[i]);
        cs2_1_next = scp_pkg::C2W'(cone.half_cos) * scp_pkg::C2W'(cone.half_cos);
        sn2_1_next = scp_pkg::C2W'(cone.half_sin) * scp_pkg::C2W'(cone.half_sin);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sne2_next[i]  = scp_pkg::SNEW'(sn_s) * scp_pkg::SNEW'(e1_reg[i]);
            rada2_next[i] = scp_pkg::RAW'(rad_s) * scp_pkg::RAW'(a1_reg[i]);
            ae2_next[i]   = scp_pkg::AEW'(a1_reg[i]) * scp_pkg::AEW'(e1_reg[i]);
            eneg[i]       = -e1_reg[i];
            eabs2_next[i] = e1_reg[i][scp_pkg::EW-1] ? eneg[i][scp_pkg::EW-2:0]
                                                     : e1_reg[i][scp_pkg::EW-2:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp3_next[i]  = scp_pkg::DPW'(sne2_reg[i]) + scp_pkg::DPW'(rada2_reg[i]);
            esq3_next[i] = scp_pkg::ESQW'(eabs2_reg[i]) * scp_pkg::ESQW'(eabs2_reg[i]);
        end
        n3_next = -scp_pkg::NW'(ae2_reg[0]) - scp_pkg::NW'(ae2_reg[1])
                  - scp_pkg::NW'(ae2_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            adp4_next[i]   = scp_pkg::ADPW'(a3_reg[i]) * scp_pkg::ADPW'(dp3_reg[i]);
            dpneg[i]       = -dp3_reg[i];
            dpabs4_next[i] = dp3_reg[i][scp_pkg::DPW-1] ? dpneg[i][scp_pkg::DPW-2:0]
                                                        : dp3_reg[i][scp_pkg::DPW-2:0];
        end
        elen2_4_next = scp_pkg::ELW'(esq3_reg[0]) + scp_pkg::ELW'(esq3_reg[1])
                       + scp_pkg::ELW'(esq3_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            e1_reg     <= e1_next;
            a1_reg     <= a;
            sn1_reg    <= cone.half_sin;
            cs2_reg[1] <= cs2_1_next;
            sn2_reg[1] <= sn2_1_next;
        end
        if (en[2])
        begin
            sne2_reg   <= sne2_next;
            rada2_reg  <= rada2_next;
            ae2_reg    <= ae2_next;
            eabs2_reg  <= eabs2_next;
            a2_reg     <= a1_reg;
            cs2_reg[2] <= cs2_reg[1];
            sn2_reg[2] <= sn2_reg[1];
        end
        if (en[3])
        begin
            dp3_reg    <= dp3_next;
            n3_reg     <= n3_next;
            esq3_reg   <= esq3_next;
            a3_reg     <= a2_reg;
            cs2_reg[3] <= cs2_reg[2];
            sn2_reg[3] <= sn2_reg[2];
        end
        if (en[4])
        begin
            adp4_reg    <= adp4_next;
            dpabs4_reg  <= dpabs4_next;
            elen2_4_reg <= elen2_4_next;
            n4_reg      <= n3_reg;
            cs2_reg[4]  <= cs2_reg[3];
            sn2_reg[4]  <= sn2_reg[3];
        end
    end

    assign f.adp   = adp4_reg;
    assign f.dpabs = dpabs4_reg;
    assign f.elen2 = elen2_4_reg;
    assign f.n     = n4_reg;
    assign f.cs2   = cs2_reg[4];
    assign f.sn2   = sn2_reg[4];

endmodule

// ===== src/scp_quad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_quad
// Stages 5-12: squared lengths, wide squared compares and the hit decision.
// ----------------------------------------------------------------------------
module scp_quad (
    input  logic                         clk,
    input  scp_pkg::stage_en_t           en,
    input  logic [scp_pkg::RADW-1:0]     rad,
    input  scp_pkg::front_t              f,
    output logic                         hit
);

    localparam int DPSQ_LW = 24;
    localparam int NSQ_LW  = 25;
    localparam int ESN_LW  = 22;
    localparam int DOT_LW  = 22;
    localparam int RHS_LW  = 25;

    logic signed [scp_pkg::DOTW-1:0] dot5_next;
    logic signed [scp_pkg::DOTW-1:0] dot5_reg;
    logic [scp_pkg::DPSQW-1:0]       dpsq [3];
    logic [scp_pkg::NSQW-1:0]        nsq;
    logic [scp_pkg::ESNW-1:0]        esn;
    logic [scp_pkg::SQW-1:0]         dot2;
    logic [scp_pkg::RHSW-1:0]        rhs;
    logic [scp_pkg::LENW-1:0]        len2_next;
    logic [scp_pkg::LENW-1:0]        len2_reg;
    logic [scp_pkg::R2W-1:0]         rad2_reg;
    logic                            b2_next;
    logic                            hit_next;
    logic                            hit_reg;

    logic                      nneg_reg   [5:7];
    logic [scp_pkg::ELW-1:0]   elen2_reg  [5:7];
    logic [scp_pkg::C2W-1:0]   cs2_reg    [5:8];
    logic                      dotneg_reg [6:11];
    logic [scp_pkg::SQW-1:0]   dot2_reg   [9:11];
    logic                      b2_reg     [8:11];

    // the user must keep radius static while items are in flight; not enforced here
    always_ff @(posedge clk)
    begin
        rad2_reg <= scp_pkg::R2W'(rad) * scp_pkg::R2W'(rad);
    end

    assign dot5_next = scp_pkg::DOTW'(f.adp[0]) + scp_pkg::DOTW'(f.adp[1])
                       + scp_pkg::DOTW'(f.adp[2]);

    // |D'_i|^2, stages 5-7
    for (genvar i = 0; i < 3; i++)
    begin : g_dpsq
        scp_wmul #(
            .AW (scp_pkg::DPMW),
            .BW (scp_pkg::DPMW),
            .LW (DPSQ_LW)
        ) u_dpsq (
            .clk (clk),
            .en  (en[7:5]),
            .a   (f.dpabs[i]),
            .b   (f.dpabs[i]),
            .p   (dpsq[i])
        );
    end

    // n^2, only meaningful when n >= 0, stages 5-7
    scp_wmul #(
        .AW (scp_pkg::NMW),
        .BW (scp_pkg::NMW),
        .LW (NSQ_LW)
    ) u_nsq (
        .clk (clk),
        .en  (en[7:5]),
        .a   (f.n[scp_pkg::NMW-1:0]),
        .b   (f.n[scp_pkg::NMW-1:0]),
        .p   (nsq)
    );

    // |E|^2 * sin^2, stages 5-7
    scp_wmul #(
        .AW (scp_pkg::ELW),
        .BW (scp_pkg::C2W),
        .LW (ESN_LW)
    ) u_esn (
        .clk (clk),
        .en  (en[7:5]),
        .a   (f.elen2),
        .b   (f.sn2),
        .p   (esn)
    );

    // (A.D')^2, only meaningful when A.D' >= 0, stages 6-8
    scp_wmul #(
        .AW (scp_pkg::DOTW - 1),
        .BW (scp_pkg::DOTW - 1),
        .LW (DOT_LW)
    ) u_dot2 (
        .clk (clk),
        .en  (en[8:6]),
        .a   (dot5_reg[scp_pkg::DOTW-2:0]),
        .b   (dot5_reg[scp_pkg::DOTW-2:0]),
        .p   (dot2)
    );

    // |D'|^2 * cos^2, stages 9-11
    scp_wmul #(
        .AW (scp_pkg::LENW),
        .BW (scp_pkg::C2W),
        .LW (RHS_LW)
    ) u_rhs (
        .clk (clk),
        .en  (en[11:9]),
        .a   (len2_reg),
        .b   (cs2_reg[8]),
        .p   (rhs)
    );

    assign len2_next = scp_pkg::LENW'(dpsq[0]) + scp_pkg::LENW'(dpsq[1])
                       + scp_pkg::LENW'(dpsq[2]);

    // second half of the test: n < 0 or outside K' -> hit, inside K' -> |E| <= r
    assign b2_next = !nneg_reg[7] || (nsq < scp_pkg::NSQW'(esn))
                     || (elen2_reg[7] <= scp_pkg::ELW'(rad2_reg));

    assign hit_next = !dotneg_reg[11] && (dot2_reg[11] >= scp_pkg::SQW'(rhs))
                      && b2_reg[11];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dot5_reg     <= dot5_next;
            nneg_reg[5]  <= !f.n[scp_pkg::NW-1];
            elen2_reg[5] <= f.elen2;
            cs2_reg[5]   <= f.cs2;
        end
        for (int s = 6; s <= 7; s++)
        begin
            if (en[s])
            begin
                nneg_reg[s]  <= nneg_reg[s-1];
                elen2_reg[s] <= elen2_reg[s-1];
            end
        end
        for (int s = 6; s <= 8; s++)
        begin
            if (en[s])
                cs2_reg[s] <= cs2_reg[s-1];
        end
        if (en[6])
            dotneg_reg[6] <= dot5_reg[scp_pkg::DOTW-1];
        for (int s = 7; s <= 11; s++)
        begin
            if (en[s])
                dotneg_reg[s] <= dotneg_reg[s-1];
        end
        if (en[8])
        begin
            len2_reg  <= len2_next;
            b2_reg[8] <= b2_next;
        end
        if (en[9])
            dot2_reg[9] <= dot2;
        for (int s = 10; s <= 11; s++)
        begin
            if (en[s])
                dot2_reg[s] <= dot2_reg[s-1];
        end
        for (int s = 9; s <= 11; s++)
        begin
            if (en[s])
                b2_reg[s] <= b2_reg[s-1];
        end
        if (en[12])
            hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

// ===== src/sphere_cone_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cone_intersect
// Sphere versus cone hit test, one cone per stream transaction.
// ----------------------------------------------------------------------------
// The sphere (center, radius) sits in four configuration registers; each
// input transaction carries one cone (apex, unit axis, cos and sin of the
// half-angle) and yields exactly one output transaction holding the hit bit.
// The datapath is a 12-stage pipeline whose last stage is the output
// register: a transaction can be accepted every clock while the output
// side is not stalled, and its result moves through the stages in order
// until it is held in the output register for the output side to take.
// Every stage carries a valid bit and loads when it is empty or its
// successor loads, so a stalled output holds only the stages that are full
// and the input keeps accepting until the pipeline is packed. The latency
// is set by the wide squared compares: each wide product (up to 65x65 bits)
// is split into limb multipliers of at most 25x25 bits, multiplied and
// summed over three stages, and the |D'|^2 * cos^2 product starts only once
// |D'|^2 is summed.
// All arithmetic is exact; nothing rounds or saturates. Write the registers
// only while no transaction is in flight.
// Register map (cfg_addr): 0 center x, 1 center y, 2 center z (signed
// Q16.16), 3 radius (unsigned Q15.16, cfg_wdata[30:0]); all reset to zero.
// ----------------------------------------------------------------------------
module sphere_cone_intersect (
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration writes
    input  logic                           cfg_we,
    input  logic [scp_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [scp_pkg::CFG_DW-1:0]     cfg_wdata,

    // cone queries
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // s_axis_tdata, from bit 0: apex_x[31:0], apex_y[63:32], apex_z[95:64],
    // dir_x[111:96], dir_y[127:112], dir_z[143:128], half_cos[158:144],
    // half_sin[173:159], zero pad[175:174]
    input  logic [scp_pkg::S_TDATA_W-1:0]  s_axis_tdata,

    // hit results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // m_axis_tdata, from bit 0: hit[0], zero pad[7:1]
    output logic [scp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    scp_pkg::sphere_t   sph_reg;
    scp_pkg::cone_t     cone;
    scp_pkg::front_t    front;
    scp_pkg::stage_en_t en;
    scp_pkg::stage_en_t vld_reg;
    scp_pkg::stage_en_t vld_next;
    logic               hit;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                scp_pkg::CFG_CENTER_X: sph_reg.center_x <= cfg_wdata;
                scp_pkg::CFG_CENTER_Y: sph_reg.center_y <= cfg_wdata;
                scp_pkg::CFG_CENTER_Z: sph_reg.center_z <= cfg_wdata;
                scp_pkg::CFG_RADIUS:   sph_reg.radius   <= cfg_wdata[scp_pkg::RADW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    assign cone.apex_x   = s_axis_tdata[31:0];
    assign cone.apex_y   = s_axis_tdata[63:32];
    assign cone.apex_z   = s_axis_tdata[95:64];
    assign cone.dir_x    = s_axis_tdata[111:96];
    assign cone.dir_y    = s_axis_tdata[127:112];
    assign cone.dir_z    = s_axis_tdata[143:128];
    assign cone.half_cos = s_axis_tdata[158:144];
    assign cone.half_sin = s_axis_tdata[173:159];

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when its
    // successor loads, so bubbles are squeezed out under back-pressure.
    // ------------------------------------------------------------------
    always_comb
    begin
        en[scp_pkg::NSTAGE] = !vld_reg[scp_pkg::NSTAGE] || m_axis_tready;
        for (int k = scp_pkg::NSTAGE - 1; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[1])
            vld_next[1] = s_axis_tvalid;
        for (int k = 2; k <= scp_pkg::NSTAGE; k++)
        begin
            if (en[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_axis_tready = en[1];

    // ------------------------------------------------------------------
    // Datapath: vector terms (stages 1-4), squared compares (5-12)
    // ------------------------------------------------------------------
    scp_front u_front (
        .clk  (clk),
        .en   (en),
        .sph  (sph_reg),
        .cone (cone),
        .f    (front)
    );

    scp_quad u_quad (
        .clk (clk),
        .en  (en),
        .rad (sph_reg.radius),
        .f   (front),
        .hit (hit)
    );

    // ------------------------------------------------------------------
    // Output: last pipeline stage is the output register
    // ------------------------------------------------------------------
    assign m_axis_tvalid = vld_reg[scp_pkg::NSTAGE];
    assign m_axis_tdata  = {(scp_pkg::M_TDATA_W - 1)'(0), hit};

endmodule
